// ----- rtl/tun_pkg.sv -----
// Shared types and constants for the triangle unit-normal core.
// Holds the item record that travels along the normalizer chain.
// No dependencies.
package tun_pkg;

  localparam int CoordW = 16;                    // corner coordinate width
  localparam int EdgeW  = CoordW + 1;            // edge vector component
  localparam int ProdW  = 2 * EdgeW;             // one cross-product term
  localparam int MagW   = 34;                    // |n| component magnitude
  localparam int SqW    = 2 * MagW;              // n component squared
  localparam int LenW   = SqW + 2;               // sum of three squares
  localparam int QW     = 15;                    // unit component magnitude
  localparam int NormW  = 16;                    // signed Q1.14 output
  localparam int TgtShift = 30;                  // 2^30 scale on the target
  localparam int W      = 104;                   // search datapath width

  // Per-component search state
  typedef struct packed {
    logic [W-1:0]  a;    // (2q-1)^2 * L
    logic [W-1:0]  b;    // q * L
    logic [W-1:0]  t;    // 2^30 * n^2
    logic [QW-1:0] q;    // magnitude decided so far
    logic          neg;  // component sign
  } tun_lane_t;

  // One triangle in flight through the chain
  typedef struct packed {
    logic [W-1:0]        len2;
    tun_lane_t [2:0]     lane;
    logic                degen;
  } tun_item_t;

endpackage

// ----- rtl/tun_front.sv -----
// Front end of the unit-normal core: edges, cross product, squared length.
// Five registered stages feeding the normalizer chain. Uses tun_pkg.
module tun_front
  import tun_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_i,
  input  logic [9*CoordW-1:0]      coord_i,
  output logic                     vld_o,
  output tun_item_t                item_o
);

  logic [4:0]                 vld_r;
  logic signed [EdgeW-1:0]    e1_r [3];
  logic signed [EdgeW-1:0]    e2_r [3];
  logic signed [ProdW-1:0]    p_r [6];
  logic [MagW-1:0]            mag3_r [3];
  logic [2:0]                 neg3_r;
  logic [SqW-1:0]             sq_r [3];
  logic [2:0]                 neg4_r;
  tun_item_t                  item_r;

  logic signed [EdgeW-1:0]    crd [9];
  logic signed [ProdW:0]      n_nxt [3];
  tun_item_t                  item_nxt;

  // Sign-extended corner coordinates
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      crd[i] = EdgeW'($signed(coord_i[i*CoordW +: CoordW]));
    end
  end

  // Cross product difference, stage 3 input
  always_comb begin
    n_nxt[0] = (ProdW+1)'(p_r[0]) - (ProdW+1)'(p_r[1]);
    n_nxt[1] = (ProdW+1)'(p_r[2]) - (ProdW+1)'(p_r[3]);
    n_nxt[2] = (ProdW+1)'(p_r[4]) - (ProdW+1)'(p_r[5]);
  end

  // Squared length and per-lane targets, stage 5 input
  always_comb begin
    item_nxt      = '0;
    item_nxt.len2 = W'(LenW'(sq_r[0]) + LenW'(sq_r[1]) + LenW'(sq_r[2]));
    for (int i = 0; i < 3; i++) begin
      item_nxt.lane[i].a   = item_nxt.len2;
      item_nxt.lane[i].b   = '0;
      item_nxt.lane[i].t   = W'(sq_r[i]) << TgtShift;
      item_nxt.lane[i].q   = '0;
      item_nxt.lane[i].neg = neg4_r[i];
    end
    item_nxt.degen = (item_nxt.len2 == '0);
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= crd[3+i] - crd[i];
        e2_r[i] <= crd[6+i] - crd[i];
      end
      p_r[0] <= e1_r[1] * e2_r[2];
      p_r[1] <= e1_r[2] * e2_r[1];
      p_r[2] <= e1_r[2] * e2_r[0];
      p_r[3] <= e1_r[0] * e2_r[2];
      p_r[4] <= e1_r[0] * e2_r[1];
      p_r[5] <= e1_r[1] * e2_r[0];
      for (int i = 0; i < 3; i++) begin
        neg3_r[i] <= n_nxt[i][ProdW];
        mag3_r[i] <= n_nxt[i][ProdW] ? MagW'(-n_nxt[i]) : MagW'(n_nxt[i]);
        sq_r[i]   <= mag3_r[i] * mag3_r[i];
      end
      neg4_r <= neg3_r;
      item_r <= item_nxt;
    end
  end

  assign vld_o  = vld_r[4];
  assign item_o = item_r;

endmodule

// ----- rtl/tun_cell.sv -----
// One normalizer cell: decides one bit of each unit component magnitude.
// Keeps (2q-1)^2*L and q*L current with shifts and adds. Uses tun_pkg.
module tun_cell
  import tun_pkg::*;
#(
  parameter int BIT = 0
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      vld_i,
  input  tun_item_t item_i,
  output logic      vld_o,
  output tun_item_t item_o
);

  logic      vld_r;
  tun_item_t item_r;
  tun_item_t item_nxt;
  logic [W-1:0] lsh, d, cand;

  // Trial-set this bit; keep it if the rounding bound still holds
  always_comb begin
    item_nxt = item_i;
    lsh  = '0;
    d    = '0;
    cand = '0;
    for (int i = 0; i < 3; i++) begin
      lsh  = item_i.len2 << BIT;
      d    = (item_i.lane[i].b << 1) - item_i.len2 + lsh;
      cand = item_i.lane[i].a + (d << (BIT + 2));
      if (cand <= item_i.lane[i].t) begin
        item_nxt.lane[i].a      = cand;
        item_nxt.lane[i].b      = item_i.lane[i].b + lsh;
        item_nxt.lane[i].q[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;

endmodule

// ----- rtl/triangle_unit_normal_core.sv -----
// Top level of the triangle unit-normal core.
// Front end, a row of fifteen normalizer cells and the output register.
// Uses tun_pkg, tun_front, tun_cell.
//
//  channel | direction | tdata                          | tuser
//  in_     | slave     | a_x..c_z, 9 x 16 bits          | -
//  out_    | master    | norm_x, norm_y, norm_z (16 ea) | degenerate
//
// One triangle per clock while out_tready does not hold the pipeline; 5 front
// stages, one cell per result bit over 15 bits, 1 output register.
// Synchronous active-low reset clears all valid bits.
// The whole pipeline holds while a result waits and out_tready is low.
module triangle_unit_normal_core
  import tun_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [143:0]        in_tdata,   // a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [47:0]         out_tdata,  // norm_x, norm_y, norm_z
  output logic [0:0]          out_tuser   // degenerate
);

  logic        en;
  logic        vld [QW+1];
  tun_item_t   item [QW+1];
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_degen_r;
  logic [47:0] out_data_nxt;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  tun_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_tvalid),
    .coord_i (in_tdata),
    .vld_o   (vld[0]),
    .item_o  (item[0])
  );

  // Cells from the top magnitude bit down
  for (genvar g = 0; g < QW; g++) begin : g_cell
    tun_cell #(.BIT(QW - 1 - g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (vld[g]),
      .item_i (item[g]),
      .vld_o  (vld[g+1]),
      .item_o (item[g+1])
    );
  end

  // Apply signs, zero a degenerate result
  always_comb begin
    out_data_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (!item[QW].degen) begin
        out_data_nxt[i*NormW +: NormW] = item[QW].lane[i].neg ?
          -NormW'(item[QW].lane[i].q) : NormW'(item[QW].lane[i].q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r  <= out_data_nxt;
      out_degen_r <= item[QW].degen;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_degen_r;

endmodule

// ----- rtl/tun_checker.sv -----
// Port-level checks for triangle_unit_normal_core, attached by bind.
// Depends only on the top level's ports.
module tun_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata,
  input logic [0:0]   out_tuser
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Nothing comes out right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid after reset");

  // Degenerate results are all zero
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 48'd0)
    else $error("degenerate result not zero");

  // A proper normal has a nonzero component
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata != 48'd0)
    else $error("zero normal without flag");

  // Components stay within unit range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(out_tdata[15:0])  >= -16384 && $signed(out_tdata[15:0])  <= 16384) &&
      ($signed(out_tdata[31:16]) >= -16384 && $signed(out_tdata[31:16]) <= 16384) &&
      ($signed(out_tdata[47:32]) >= -16384 && $signed(out_tdata[47:32]) <= 16384))
    else $error("component out of range");

endmodule

bind triangle_unit_normal_core tun_checker u_tun_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/tb_triangle_unit_normal_core.sv -----
// Testbench for triangle_unit_normal_core: random and corner-case triangles
// are streamed in and every normal is checked against an exact predictor.
// Depends on tun_pkg and the core RTL.
`timescale 1ns / 100ps

class normal_scoreboard;
  typedef struct {
    logic [15:0] nx, ny, nz;
    logic        degen;
  } normal_t;

  normal_t pending_normals[$];
  int      errors;

  // round-half-up magnitude of 16384*|n|/sqrt(len2)
  function automatic logic [15:0] unit_comp(longint n, logic [103:0] len2);
    logic [103:0] m, tgt, lhs;
    int lo, hi, mid;
    logic [15:0] q;
    m = (n < 0) ? -n : n;
    tgt = (m * m) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = len2 * ((2 * mid - 1) * (2 * mid - 1));
      if (lhs <= tgt) lo = mid;
      else hi = mid - 1;
    end
    q = lo[15:0];
    if (n < 0) q = -q;
    return q;
  endfunction

  function void note_triangle(logic [143:0] tri_data);
    longint c[9];
    longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
    logic [103:0] len2, sx, sy, sz;
    normal_t r;
    for (int i = 0; i < 9; i++) c[i] = longint'($signed(tri_data[16*i +: 16]));
    e1x = c[3] - c[0]; e1y = c[4] - c[1]; e1z = c[5] - c[2];
    e2x = c[6] - c[0]; e2y = c[7] - c[1]; e2z = c[8] - c[2];
    nx = e1y * e2z - e1z * e2y;
    ny = e1z * e2x - e1x * e2z;
    nz = e1x * e2y - e1y * e2x;
    sx = (nx < 0) ? -nx : nx;
    sy = (ny < 0) ? -ny : ny;
    sz = (nz < 0) ? -nz : nz;
    len2 = sx * sx + sy * sy + sz * sz;
    if (len2 == 0) begin
      r.nx = 0; r.ny = 0; r.nz = 0; r.degen = 1'b1;
    end else begin
      r.nx = unit_comp(nx, len2);
      r.ny = unit_comp(ny, len2);
      r.nz = unit_comp(nz, len2);
      r.degen = 1'b0;
    end
    pending_normals.insert(pending_normals.size(), r);
  endfunction

  task report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task check_normal(logic [47:0] data, logic degen);
    normal_t e;
    if (pending_normals.size() == 0) begin
      report("unexpected transfer", data[15:0], 16'h0);
      return;
    end
    e = pending_normals.pop_front();
    if (data[15:0] !== e.nx) report("norm_x", data[15:0], e.nx);
    if (data[31:16] !== e.ny) report("norm_y", data[31:16], e.ny);
    if (data[47:32] !== e.nz) report("norm_z", data[47:32], e.nz);
    if (degen !== e.degen) report("degenerate", {15'b0, degen}, {15'b0, e.degen});
  endtask
endclass

module tb_triangle_unit_normal_core;
  import tun_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;
  logic [0:0]   out_tuser;

  normal_scoreboard sb;
  logic         sending_done = 1'b0;
  logic [143:0] directed_tris[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangle_unit_normal_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  function automatic logic [143:0] pack_tri(int v[9]);
    logic [143:0] d;
    for (int i = 0; i < 9; i++) d[16*i +: 16] = v[i][15:0];
    return d;
  endfunction

  function automatic logic [143:0] random_tri();
    logic [143:0] d;
    int sel, sh;
    sel = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'($urandom());
    if (sel == 0) begin
      // degenerate: two or all three corners coincident
      d[143:96] = d[47:0];
      if ($urandom_range(0, 1)) d[95:48] = d[47:0];
    end else if (sel < 4) begin
      // small triangle near a random base point
      sh = $urandom_range(0, 8);
      for (int i = 3; i < 9; i++)
        d[16*i +: 16] = d[16*(i%3) +: 16] + (16'($signed(16'($urandom())) >>> (15 - sh)));
    end else if (sel == 4) begin
      // axis-aligned triangle, one coordinate shared
      d[16*5 +: 16] = d[16*2 +: 16];
      d[16*8 +: 16] = d[16*2 +: 16];
    end
    return d;
  endfunction

  // drive one triangle, hold until accepted
  task send_tri(logic [143:0] d);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_triangle(d);
  endtask

  // accepted result transfers go to the scoreboard
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_normal(out_tdata, out_tuser[0]);

  // receiver: a long hold-off early, then a random stall pattern
  initial begin
    int mode;
    @(posedge clk iff rst_n);
    repeat (150) @(posedge clk);
    for (int i = 0; i < 120; i++) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        out_tready <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(0, 3) != 0)
                                                       : ($urandom_range(0, 1) == 1);
        @(posedge clk);
      end
    end
  end

  // sender
  initial begin
    int v[9];
    int burst;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner cases: extremes, degenerate, axis normals, sign ties
    v = '{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{32767, -32768, 0, -32768, 32767, 0, 32767, 32767, -32768};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{0, 0, 0, 0, 1, 0, 0, 0, 1};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{0, 0, 0, 1, 0, 0, 0, 0, -1};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{0, 0, 0, 1, 1, 0, -1, 1, 0};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 1};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{0, 0, 0, 1, 2, 0, 0, 0, 3};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{-32768, 0, 0, 32767, 0, 0, 0, 32767, -32768};
    directed_tris = {directed_tris, pack_tri(v)};
    v = '{100, 200, 300, 101, 200, 300, 100, 200, 301};
    directed_tris = {directed_tris, pack_tri(v)};
    foreach (directed_tris[i]) send_tri(directed_tris[i]);

    // random bursts with gaps
    for (int n = 0; n < 2000; ) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst; k++, n++) send_tri(random_tri());
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    while (sb.pending_normals.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    sending_done = 1'b1;
  end

  // final verdict
  initial begin
    wait (sending_done);
    if (sb.errors == 0 && sb.pending_normals.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end
endmodule
